/* rtl/core/lhdt_pkg.sv */
// Package for the linear hash dedup table: sizes, status codes, sequencer states.
// No dependencies.
`default_nettype none
package lhdt_pkg;
    localparam int MAX_BUCKETS      = 64;
    localparam int SLOTS_PER_BUCKET = 16;
    localparam int KEY_WIDTH        = 32;
    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int SLOT_W  = $clog2(SLOTS_PER_BUCKET);
    localparam int FILL_W  = SLOT_W + 1;
    localparam int ADDR_W  = BKT_W + SLOT_W;
    localparam int DEPTH   = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int ROUND_W = BKT_W + 1;

    typedef logic [1:0] status_t;
    localparam status_t ST_DUP   = 2'd0;
    localparam status_t ST_INS   = 2'd1;
    localparam status_t ST_SPLIT = 2'd2;
    localparam status_t ST_DROP  = 2'd3;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FRD, S_FILL, S_SRD, S_SCMP, S_APP, S_SPLIT0, S_SPLIT1,
        S_RRD, S_RWAIT, S_RWR, S_ADV, S_OUT
    } state_t;
endpackage
`default_nettype wire

/* rtl/core/lhdt_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lhdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* rtl/core/linear_hash_dedup_table.sv */
// Top level of the linear hash dedup table: sequencer, fill count RAM, key RAM.
// Depends on lhdt_pkg and lhdt_ram.
`default_nettype none
// One key per request. After reset a clearing pass zeroes the bucket fill counts, and the
// block is not ready until it ends. A lookup reads its bucket's fill count, then scans the
// slots through the registered key RAM, each slot in the states S_SRD, S_FILL and S_SCMP; an
// insert that splits then rehashes the split bucket, each slot in S_RRD, S_RWAIT and S_RWR.
// The next request can be taken in the cycle after the result is accepted.
module linear_hash_dedup_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // key
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // key_out[31:0], status[33:32], zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data        // bucket_capacity
);
    localparam int KW = lhdt_pkg::KEY_WIDTH;
    localparam int BW = lhdt_pkg::BKT_W;
    localparam int SW = lhdt_pkg::SLOT_W;
    localparam int FW = lhdt_pkg::FILL_W;
    localparam int RW = lhdt_pkg::ROUND_W;
    localparam int NB = lhdt_pkg::MAX_BUCKETS;

    lhdt_pkg::state_t state_reg, state_next;
    logic [BW-1:0] clr_reg;
    logic [RW-1:0] round_reg;
    logic [BW-1:0] sp_reg;
    logic [3:0]    cap_reg;
    logic [KW-1:0] key_reg;
    logic [BW-1:0] bkt_reg;
    logic [FW-1:0] idx_reg;
    logic [FW-1:0] n_reg;
    lhdt_pkg::status_t status_reg;
    logic          out_valid_reg;
    logic [31:0]   out_key_reg;
    lhdt_pkg::status_t out_status_reg;

    logic          ram_we;
    logic [lhdt_pkg::ADDR_W-1:0] ram_addr;
    logic [KW-1:0] ram_wdata, ram_rdata;

    logic          fill_we;
    logic [BW-1:0] fill_addr;
    logic [FW-1:0] fill_wdata, fill_rdata;

    lhdt_ram #(.WIDTH(KW), .DEPTH(lhdt_pkg::DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    lhdt_ram #(.WIDTH(FW), .DEPTH(NB)) u_fill (
        .clk(clk), .we(fill_we), .addr(fill_addr), .wdata(fill_wdata), .rdata(fill_rdata)
    );

    logic [BW:0]   mask1, mask2;
    logic [BW-1:0] home_lo, home, dest;
    logic [FW-1:0] dest_fill, cur_fill;
    logic          split_ok;

    assign mask1    = round_reg[BW:0] - 1'b1;
    assign mask2    = {round_reg[BW-1:0], 1'b0} - 1'b1;
    assign home_lo  = BW'(s_axis_tdata[BW-1:0] & mask1[BW-1:0]);
    assign home     = (home_lo < sp_reg) ? BW'(s_axis_tdata[BW-1:0] & mask2[BW-1:0]) : home_lo;
    assign dest     = BW'(ram_rdata[BW-1:0] & mask2[BW-1:0]);
    assign dest_fill = fill_rdata;
    assign cur_fill  = fill_rdata;
    assign split_ok  = ({1'b0, round_reg} << 1) <= (RW+1)'(NB);

    assign s_axis_tready = (state_reg == lhdt_pkg::S_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_status_reg, out_key_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lhdt_pkg::S_CLR:    if (clr_reg == BW'(NB - 1)) state_next = lhdt_pkg::S_IDLE;
            lhdt_pkg::S_IDLE:   if (s_axis_tvalid && s_axis_tready) state_next = lhdt_pkg::S_FRD;
            lhdt_pkg::S_FRD:    state_next = lhdt_pkg::S_SRD;
            lhdt_pkg::S_SRD:    state_next = (idx_reg < cur_fill) ? lhdt_pkg::S_FILL
                                                                  : lhdt_pkg::S_APP;
            lhdt_pkg::S_FILL:   state_next = lhdt_pkg::S_SCMP;
            lhdt_pkg::S_SCMP:   state_next = (ram_rdata == key_reg) ? lhdt_pkg::S_OUT
                                                                    : lhdt_pkg::S_SRD;
            lhdt_pkg::S_APP:
            begin
                if (cur_fill >= FW'(lhdt_pkg::SLOTS_PER_BUCKET))
                    state_next = lhdt_pkg::S_OUT;
                else if ((cur_fill + 1'b1) > {1'b0, cap_reg} && split_ok)
                    state_next = lhdt_pkg::S_SPLIT0;
                else
                    state_next = lhdt_pkg::S_OUT;
            end
            lhdt_pkg::S_SPLIT0: state_next = lhdt_pkg::S_SPLIT1;
            lhdt_pkg::S_SPLIT1: state_next = lhdt_pkg::S_RRD;
            lhdt_pkg::S_RRD:    state_next = (idx_reg < n_reg) ? lhdt_pkg::S_RWAIT
                                                               : lhdt_pkg::S_ADV;
            lhdt_pkg::S_RWAIT:  state_next = lhdt_pkg::S_RWR;
            lhdt_pkg::S_RWR:    state_next = lhdt_pkg::S_RRD;
            lhdt_pkg::S_ADV:    state_next = lhdt_pkg::S_OUT;
            lhdt_pkg::S_OUT:    state_next = lhdt_pkg::S_IDLE;
            default:            state_next = lhdt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ram_we     = 1'b0;
        ram_addr   = {bkt_reg, idx_reg[SW-1:0]};
        ram_wdata  = key_reg;
        fill_we    = 1'b0;
        fill_addr  = bkt_reg;
        fill_wdata = cur_fill + 1'b1;
        case (state_reg)
            lhdt_pkg::S_CLR:
            begin
                fill_we    = 1'b1;
                fill_addr  = clr_reg;
                fill_wdata = '0;
            end
            lhdt_pkg::S_APP:
            begin
                ram_we   = cur_fill < FW'(lhdt_pkg::SLOTS_PER_BUCKET);
                ram_addr = {bkt_reg, cur_fill[SW-1:0]};
                fill_we  = cur_fill < FW'(lhdt_pkg::SLOTS_PER_BUCKET);
            end
            lhdt_pkg::S_SPLIT0: fill_addr = sp_reg;
            lhdt_pkg::S_SPLIT1:
            begin
                fill_we    = 1'b1;
                fill_addr  = sp_reg;
                fill_wdata = '0;
            end
            lhdt_pkg::S_RWAIT: fill_addr = dest;
            lhdt_pkg::S_RWR:
            begin
                ram_we     = dest_fill < FW'(lhdt_pkg::SLOTS_PER_BUCKET);
                ram_addr   = {dest, dest_fill[SW-1:0]};
                ram_wdata  = ram_rdata;
                fill_we    = dest_fill < FW'(lhdt_pkg::SLOTS_PER_BUCKET);
                fill_addr  = dest;
                fill_wdata = dest_fill + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhdt_pkg::S_CLR;
            clr_reg       <= '0;
            round_reg     <= RW'(2);
            sp_reg        <= '0;
            cap_reg       <= 4'd2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid) cap_reg <= cfg_data;
            if (m_axis_tvalid && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                lhdt_pkg::S_CLR: clr_reg <= clr_reg + 1'b1;
                lhdt_pkg::S_ADV:
                begin
                    if ({1'b0, sp_reg} + 1'b1 >= round_reg[BW:0])
                    begin
                        sp_reg    <= '0;
                        round_reg <= round_reg << 1;
                    end
                    else
                        sp_reg <= sp_reg + 1'b1;
                end
                lhdt_pkg::S_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lhdt_pkg::S_IDLE:
            begin
                key_reg    <= s_axis_tdata;
                bkt_reg    <= home;
                idx_reg    <= '0;
                status_reg <= lhdt_pkg::ST_INS;
            end
            lhdt_pkg::S_SCMP:
            begin
                idx_reg <= idx_reg + 1'b1;
                if (ram_rdata == key_reg) status_reg <= lhdt_pkg::ST_DUP;
            end
            lhdt_pkg::S_APP:
            begin
                if (cur_fill >= FW'(lhdt_pkg::SLOTS_PER_BUCKET))
                    status_reg <= lhdt_pkg::ST_DROP;
                else if ((cur_fill + 1'b1) > {1'b0, cap_reg} && split_ok)
                    status_reg <= lhdt_pkg::ST_SPLIT;
            end
            lhdt_pkg::S_SPLIT0:
            begin
                bkt_reg <= sp_reg;
                idx_reg <= '0;
            end
            lhdt_pkg::S_SPLIT1: n_reg <= fill_rdata;
            lhdt_pkg::S_RWR: idx_reg <= idx_reg + 1'b1;
            lhdt_pkg::S_OUT:
            begin
                out_key_reg    <= key_reg;
                out_status_reg <= status_reg;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == lhdt_pkg::S_IDLE))
        else $error("accepting while busy");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lhdt_pkg::S_OUT) |=> out_valid_reg)
        else $error("result lost");
    a_round_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(round_reg))
        else $error("round size not a power of two");
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, sp_reg} < round_reg[BW:0] || round_reg[BW])
        else $error("split pointer past round");
endmodule
`default_nettype wire

/* test/linear_hash_dedup_table_test.sv */
// Testbench for linear_hash_dedup_table: random and directed key requests checked
// against a behavioral linear-hashing table kept in the testbench. Depends on lhdt_pkg.
module linear_hash_dedup_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // key
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // key_out[31:0], status[33:32], zero
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;         // bucket_capacity

    linear_hash_dedup_table dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    typedef struct packed {
        logic [31:0]       key;
        lhdt_pkg::status_t status;
    } lookup_t;

    logic [31:0]       table_keys [lhdt_pkg::DEPTH];
    int unsigned       table_fill [lhdt_pkg::MAX_BUCKETS];
    int unsigned       round_sz;
    int unsigned       split_ptr;
    int unsigned       capacity;
    lookup_t           pending_lookups[$];
    int                errors = 0;
    int                checked = 0;
    int                split_count = 0;
    int                dup_count = 0;
    int                drop_count = 0;
    bit                calm = 1'b0;
    bit                sink_calm = 1'b0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned bucket_of(input logic [31:0] k);
        int unsigned b;
        b = k & (round_sz - 1);
        if (b < split_ptr)
            b = k & (2 * round_sz - 1);
        return b % lhdt_pkg::MAX_BUCKETS;
    endfunction

    function automatic bit table_append(input int unsigned b, input logic [31:0] k);
        if (table_fill[b] >= lhdt_pkg::SLOTS_PER_BUCKET)
            return 1'b0;
        table_keys[b * lhdt_pkg::SLOTS_PER_BUCKET + table_fill[b]] = k;
        table_fill[b]++;
        return 1'b1;
    endfunction

    function automatic void table_split();
        int unsigned sp;
        int unsigned n;
        int unsigned d;
        logic [31:0] k;
        bit ok;
        sp = split_ptr % lhdt_pkg::MAX_BUCKETS;
        n = table_fill[sp];
        table_fill[sp] = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            k = table_keys[sp * lhdt_pkg::SLOTS_PER_BUCKET + i];
            d = (k & (2 * round_sz - 1)) % lhdt_pkg::MAX_BUCKETS;
            ok = table_append(d, k);
        end
        split_ptr++;
        if (split_ptr >= round_sz)
        begin
            split_ptr = 0;
            round_sz = round_sz * 2;
        end
    endfunction

    function automatic lhdt_pkg::status_t table_lookup(input logic [31:0] k);
        int unsigned b;
        b = bucket_of(k);
        for (int unsigned i = 0; i < table_fill[b]; i++)
            if (table_keys[b * lhdt_pkg::SLOTS_PER_BUCKET + i] == k)
                return lhdt_pkg::ST_DUP;
        if (!table_append(b, k))
            return lhdt_pkg::ST_DROP;
        if (table_fill[b] > capacity && 2 * round_sz <= lhdt_pkg::MAX_BUCKETS)
        begin
            table_split();
            return lhdt_pkg::ST_SPLIT;
        end
        return lhdt_pkg::ST_INS;
    endfunction

    function automatic void table_clear();
        foreach (table_fill[i])
            table_fill[i] = 0;
        round_sz = 2;
        split_ptr = 0;
    endfunction

    task automatic send_key(input logic [31:0] k);
        lookup_t e;
        do
            @(posedge clk);
        while (!calm && $urandom_range(99) < 21);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= k;
        do
            @(posedge clk);
        while (!s_axis_tready);
        e.key = k;
        e.status = table_lookup(k);
        pending_lookups = {pending_lookups, e};
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [3:0] c);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity = c;
    endtask

    always @(posedge clk)
    begin
        lookup_t e;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_lookups.size() == 0)
                report($sformatf("unexpected response key %h", m_axis_tdata[31:0]));
            else
            begin
                e = pending_lookups.pop_front();
                checked++;
                if (m_axis_tdata[31:0] !== e.key)
                    report($sformatf("key_out %h, want %h", m_axis_tdata[31:0], e.key));
                if (m_axis_tdata[33:32] !== e.status)
                    report($sformatf("key %h status %0d, want %0d",
                        e.key, m_axis_tdata[33:32], e.status));
                if (e.status == lhdt_pkg::ST_SPLIT) split_count++;
                if (e.status == lhdt_pkg::ST_DUP) dup_count++;
                if (e.status == lhdt_pkg::ST_DROP) drop_count++;
            end
        end
        m_axis_tready <= sink_calm || ($urandom_range(99) >= 21);
    end

    // extremes, negative keys, duplicates, splits at default capacity
    task automatic test_directed();
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        send_key(32'h8000_0000);
        send_key(32'h7FFF_FFFF);
        send_key(32'h0000_0000);
        send_key(32'hFFFF_FFFF);
        for (int i = 1; i <= 8; i++)
            send_key(i * 32'h0101_0101);
        send_key(32'h8000_0000);
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);
    endtask

    // same low bits until the bucket fills and inserts are dropped
    task automatic test_full_bucket();
        write_capacity(4'd15);
        for (int i = 0; i < 20; i++)
            send_key({i[25:0], 6'd0});
    endtask

    task automatic test_random(input logic [3:0] cap, input int count, input int span);
        logic [31:0] k;
        write_capacity(cap);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) == 0)
                k = $urandom();
            else
                k = $urandom_range(span) ^ {$urandom_range(1) ? 8'hFF : 8'h00, 24'h0};
            send_key(k);
        end
    endtask

    // the table is never reset between phases, so it saturates; that is fine
    task automatic test_stall_and_drain();
        calm = 1'b1;
        sink_calm = 1'b1;
        for (int i = 0; i < 60; i++)
            send_key($urandom());
        calm = 1'b0;
        sink_calm = 1'b0;
        wait_drained();
        for (int i = 0; i < 40; i++)
            send_key($urandom_range(300));
    endtask

    initial
    begin
        table_clear();
        capacity = 2;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_bucket();
        test_random(4'd1, 400, 2000);
        test_random(4'd8, 400, 600);
        test_random(4'd0, 250, 5000);
        test_stall_and_drain();
        test_random(4'd15, 300, 400);
        wait_drained();
        $display("Checked %0d responses: %0d duplicates, %0d splits, %0d dropped,",
            checked, dup_count, split_count, drop_count);
        $display("capacity settings 0, 1, 2, 8 and 15 with random stalls on both sides.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
